// ===== src/tpd_pkg.sv =====
package tpd_pkg;

  // Widest pattern index that any legal store depth needs (depth up to 256)
  localparam int IdxW = 8;
  localparam int KeyW = 32;

  localparam int MaxPositionsDef = 128;
  localparam int PatternLimitDef = 64;

  // Search token that walks down the chain of cells
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } tok_t;

  // Store write, broadcast to every cell
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } wr_t;

endpackage

// ===== src/tpd_cell.sv =====
module tpd_cell #(
  parameter int MAX_POSITIONS = 128,
  parameter int CELL_IDX      = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(MAX_POSITIONS+1)-1:0]    count,
  input  tpd_pkg::tok_t                         tok_in,
  input  tpd_pkg::wr_t                          wr,
  output tpd_pkg::tok_t                         tok_out
);
  import tpd_pkg::*;

  localparam int CntW = $clog2(MAX_POSITIONS + 1);
  localparam logic [CntW-1:0] MyCnt = CntW'(CELL_IDX);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  logic [KeyW-1:0] entry_r;
  tok_t            tok_r;
  tok_t            tok_nxt;
  logic            match;

  // Only entries below the fill count take part in the search
  assign match = tok_in.valid && !tok_in.hit && (MyCnt < count) && (entry_r == tok_in.key);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.idx = MyIdx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == MyIdx)) begin
      entry_r <= wr.key;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== src/track_tuple_pattern_dedup_top.sv =====
// Channel | Direction | Transfer fields
// in_     | input     | tdata: track_ch0..3; tlast: last_position
// out_    | output    | tdata: pattern_number, is_new, distinct_count, over_limit, capacity_full
//
// One position goes from input transfer to result in these steps: the transfer loads the
// first cell and the search token steps one cell per cycle down the chain, then the store
// and count are updated and the output register is loaded. The next input transfer is taken
// only after the result of the previous position has been loaded into the output register.
// in_tready is high only while idle; a finished search holds until the output register is
// free. Reset (rst_n low, synchronous) empties the store.
module track_tuple_pattern_dedup_top #(
  parameter int MAX_POSITIONS = tpd_pkg::MaxPositionsDef,
  parameter int PATTERN_LIMIT = tpd_pkg::PatternLimitDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] track_ch0, [15:8] track_ch1,
                                  // [23:16] track_ch2, [31:24] track_ch3
  input  logic        in_tlast,   // last_position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [6:0] pattern_number, [7] is_new,
                                  // [15:8] distinct_count, [16] over_limit,
                                  // [17] capacity_full, [23:18] zero
);
  import tpd_pkg::*;

  localparam int CntW = $clog2(MAX_POSITIONS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_POSITIONS);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            last_r, last_nxt;

  logic [6:0] res_num_r, res_num_nxt;
  logic       res_new_r, res_new_nxt;
  logic [7:0] res_dist_r, res_dist_nxt;
  logic       res_over_r, res_over_nxt;
  logic       res_full_r, res_full_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  logic [CntW-1:0] n_new;
  logic            in_xfer;
  tok_t            tok [0:MAX_POSITIONS];
  tok_t            tail;
  wr_t             wr;

  assign in_tready = (state_r == StIdle);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_xfer;
    tok[0].key   = in_tdata;
  end

  for (genvar i = 0; i < MAX_POSITIONS; i++) begin : g_cell
    tpd_cell #(
      .MAX_POSITIONS(MAX_POSITIONS),
      .CELL_IDX     (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .count  (cnt_r),
      .tok_in (tok[i]),
      .wr     (wr),
      .tok_out(tok[i+1])
    );
  end

  assign tail = tok[MAX_POSITIONS];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    res_num_nxt   = res_num_r;
    res_new_nxt   = res_new_r;
    res_dist_nxt  = res_dist_r;
    res_over_nxt  = res_over_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr            = '0;
    n_new         = cnt_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      StIdle: begin
        if (in_xfer) begin
          last_nxt  = in_tlast;
          state_nxt = StScan;
        end
      end
      StScan: begin
        if (tail.valid) begin
          res_full_nxt = 1'b0;
          if (tail.hit) begin
            res_num_nxt = 7'(tail.idx);
            res_new_nxt = 1'b0;
          end else if (cnt_r < CntMax) begin
            // Store the new tuple in the next free cell
            wr.en       = 1'b1;
            wr.idx      = IdxW'(cnt_r);
            wr.key      = tail.key;
            res_num_nxt = 7'(cnt_r);
            res_new_nxt = 1'b1;
            n_new       = cnt_r + CntW'(1);
          end else begin
            res_num_nxt  = 7'd0;
            res_new_nxt  = 1'b1;
            res_full_nxt = 1'b1;
          end
          res_dist_nxt = 8'(n_new);
          res_over_nxt = (32'(n_new) > PATTERN_LIMIT);
          cnt_nxt      = last_r ? '0 : n_new;
          state_nxt    = StHold;
        end
      end
      StHold: begin
        // Hold the result until the output register frees up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_full_r, res_over_r, res_dist_r, res_new_r, res_num_r};
          state_nxt     = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    res_num_r  <= res_num_nxt;
    res_new_r  <= res_new_nxt;
    res_dist_r <= res_dist_nxt;
    res_over_r <= res_over_nxt;
    res_full_r <= res_full_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sim/tpd_checker.sv =====
module tpd_checker #(
  parameter int MAX_POSITIONS = tpd_pkg::MaxPositionsDef,
  parameter int PATTERN_LIMIT = tpd_pkg::PatternLimitDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] track_ch0, [15:8] track_ch1,
                                  // [23:16] track_ch2, [31:24] track_ch3
  input  logic        in_tlast,   // last_position
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [6:0] pattern_number, [7] is_new,
                                  // [15:8] distinct_count, [16] over_limit,
                                  // [17] capacity_full, [23:18] zero
  output int          fail_count,
  output int          pending_results
);

  // Laid out to match out_tdata[17:0]
  typedef struct packed {
    logic       capacity_full;
    logic       over_limit;
    logic [7:0] distinct_count;
    logic       is_new;
    logic [6:0] pattern_number;
  } pattern_result_t;

  logic [31:0]     known_tuples [MAX_POSITIONS];
  int unsigned     known_count;
  pattern_result_t expected_patterns [$];

  initial begin
    fail_count = 0;
    pending_results = 0;
    known_count = 0;
  end

  // Look up the tuple among the first occurrences of this module, store it if unseen and there is room
  function automatic pattern_result_t assign_pattern(input logic [31:0] key, input logic last);
    pattern_result_t res;
    int unsigned     n;
    bit              found;
    res = '0;
    found = 1'b0;
    n = known_count;
    for (int k = 0; k < n; k++) begin
      if (!found && known_tuples[k] == key) begin
        res.pattern_number = 7'(k);
        found = 1'b1;
      end
    end
    if (!found) begin
      res.is_new = 1'b1;
      if (n < MAX_POSITIONS) begin
        known_tuples[n] = key;
        res.pattern_number = 7'(n);
        n++;
      end else begin
        res.capacity_full = 1'b1;
      end
    end
    res.distinct_count = 8'(n);
    res.over_limit = (n > PATTERN_LIMIT);
    known_count = last ? 0 : n;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pattern_result_t want;
    pattern_result_t got;
    if (!rst_n) begin
      known_count = 0;
      expected_patterns.delete();
    end else begin
      // Results belong to earlier positions, so compare before queuing a new one
      if (out_tvalid && out_tready) begin
        got = pattern_result_t'(out_tdata[17:0]);
        if (expected_patterns.size() == 0) begin
          $error("unexpected result transfer: out_tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_patterns.pop_front();
          if (got.pattern_number != want.pattern_number) begin
            $error("pattern_number: expected %0d, actual %0d",
                   want.pattern_number, got.pattern_number);
            fail_count++;
          end
          if (got.is_new != want.is_new) begin
            $error("is_new: expected %0d, actual %0d", want.is_new, got.is_new);
            fail_count++;
          end
          if (got.distinct_count != want.distinct_count) begin
            $error("distinct_count: expected %0d, actual %0d",
                   want.distinct_count, got.distinct_count);
            fail_count++;
          end
          if (got.over_limit != want.over_limit) begin
            $error("over_limit: expected %0d, actual %0d", want.over_limit, got.over_limit);
            fail_count++;
          end
          if (got.capacity_full != want.capacity_full) begin
            $error("capacity_full: expected %0d, actual %0d",
                   want.capacity_full, got.capacity_full);
            fail_count++;
          end
        end
        if (out_tdata[23:18] !== 6'd0) begin
          $error("padding: expected 0, actual %h", out_tdata[23:18]);
          fail_count++;
        end
      end
      if (in_tvalid && in_tready)
        expected_patterns.push_back(assign_pattern(in_tdata, in_tlast));
    end
    pending_results = expected_patterns.size();
  end

endmodule

// ===== sim/track_tuple_pattern_dedup_top_tb.sv =====
module track_tuple_pattern_dedup_top_tb;

  localparam int ItemTarget  = 1800;
  localparam int CycleLimit  = 2_000_000;
  localparam int DrainCycles = 150;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int          fail_count;
  int          pending_results;
  int unsigned cycle_count = 0;
  int          positions_sent = 0;
  int          tx_idle_pct = 27;
  int          rx_idle_pct = 61;
  logic [31:0] module_tuples [$];

  track_tuple_pattern_dedup_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tpd_checker u_dedup_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_position(input logic [31:0] tracks, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tracks;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    positions_sent++;
    if (last)
      module_tuples.delete();
    else
      module_tuples.push_back(tracks);
    // Swap the idle pattern, then run without idling
    if (positions_sent == 600) begin
      tx_idle_pct = 61;
      rx_idle_pct = 27;
    end else if (positions_sent == 1200) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] unseen_tuple();
    logic [31:0] base;
    int          lane;
    case ($urandom_range(3))
      0, 1: return $urandom();
      // Low track numbers make accidental matches likely
      2: return {6'd0, 2'($urandom_range(3)), 6'd0, 2'($urandom_range(3)),
                 6'd0, 2'($urandom_range(3)), 6'd0, 2'($urandom_range(3))};
      default: begin
        if (module_tuples.size() == 0)
          return $urandom();
        // Near miss: one bit flipped in one channel
        base = module_tuples[$urandom_range(module_tuples.size() - 1)];
        lane = $urandom_range(3);
        base[lane*8 +: 8] = base[lane*8 +: 8] ^ (8'd1 << $urandom_range(7));
        return base;
      end
    endcase
  endfunction

  task automatic run_module(input int len, input int reuse_pct);
    logic [31:0] tracks;
    for (int i = 0; i < len; i++) begin
      if (module_tuples.size() != 0 && $urandom_range(99) < reuse_pct)
        tracks = module_tuples[$urandom_range(module_tuples.size() - 1)];
      else
        tracks = unseen_tuple();
      send_position(tracks, i == len - 1);
    end
  endtask

  initial begin : stimulus
    logic [31:0] dir_tracks [16];
    logic        dir_last   [16];
    int          kind;
    bit          first_module;
    dir_tracks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h0000_0100, 32'h0001_0000, 32'h0100_0000,
                   32'h8000_0000, 32'h0000_00FF, 32'h0000_0100, 32'h7F7F_7F7F,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    dir_last   = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0};
    first_module = 1'b1;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes, repeats, near misses, a one-position module and a clear
    for (int i = 0; i < 16; i++)
      send_position(dir_tracks[i], dir_last[i]);
    wait_results_done();

    // Close the open module before the random part
    run_module(1, 0);

    // Random modules of mixed length; the large ones overflow the store and pass the pattern limit
    while (positions_sent < ItemTarget) begin
      kind = first_module ? 0 : $urandom_range(9);
      first_module = 1'b0;
      if (kind == 0)
        run_module($urandom_range(135, 170), 6);
      else if (kind == 1)
        run_module($urandom_range(60, 100), 30);
      else
        run_module($urandom_range(1, 30), 45);
    end

    wait_results_done();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
